// ===== hw/rtl/gfdr_pkg.sv =====
package gfdr_pkg;

    localparam int AtanEntries = 30;
    localparam int CordicStagesDefault = 16;
    localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

    localparam logic [15:0] GyroScaleReset = 16'd4096;
    localparam logic [30:0] FusionThresholdReset = 31'd68356528;
    localparam logic [15:0] WheelRadiusReset = 16'd2621;

    localparam logic [1:0] RegGyroScale = 2'd0;
    localparam logic [1:0] RegFusionThreshold = 2'd1;
    localparam logic [1:0] RegWheelRadius = 2'd2;

    // classified tick handed from front to back
    typedef struct packed {
        logic signed [15:0] wheel_delta;
        logic [31:0] inc;
        logic gyro_used;
    } gfdr_tick_t;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0: r = 32'd536870912;
            5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;
            5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;
            5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;
            5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;
            5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/gfdr_front.sv =====
module gfdr_front
    import gfdr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_wheel_delta,
    input  logic signed [31:0] s_wheel_heading_delta,
    input  logic signed [15:0] s_yaw_rate,
    input  logic [15:0]        gyro_scale,
    input  logic [30:0]        fusion_threshold,
    output logic               q_valid,
    input  logic               q_ready,
    output gfdr_tick_t         q_data
);
    // one-entry queue slot holds the classified tick
    logic       full_reg;
    gfdr_tick_t data_reg;
    logic signed [31:0] gyro_inc;
    logic signed [32:0] diff;
    logic [32:0] mag;
    logic use_gyro;

    assign gyro_inc = 32'(s_yaw_rate * $signed({1'b0, gyro_scale}));
    assign diff = 33'(gyro_inc) - 33'(s_wheel_heading_delta);
    assign mag = diff[32] ? 33'(-diff) : diff;
    assign use_gyro = mag > {2'b00, fusion_threshold};

    assign s_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_data = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            full_reg <= 1'b1;
        end else if (q_ready) begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg.wheel_delta <= s_wheel_delta;
            data_reg.inc <= use_gyro ? gyro_inc : s_wheel_heading_delta;
            data_reg.gyro_used <= use_gyro;
        end
    end
endmodule

// ===== hw/rtl/gfdr_back.sv =====
module gfdr_back
    import gfdr_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  gfdr_tick_t  q_data,
    input  logic [15:0] wheel_radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_pos_x_out,
    output logic signed [31:0] m_pos_y_out,
    output logic [31:0] m_heading_out,
    output logic        m_gyro_used
);
    localparam int Stages = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
    localparam logic [4:0] LastStage = 5'(Stages - 1);

    typedef enum logic [2:0] {IDLE, ROT, MUL1, MUL2, ACC, OUT} state_t;

    state_t state_reg;
    logic [31:0] heading_reg, pos_x_reg, pos_y_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [4:0] i_reg;
    logic [1:0] quad_reg;
    logic signed [31:0] step_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [63:0] px_reg, py_reg;
    logic gyro_reg;

    logic [31:0] head_next;
    logic [1:0] quad_next;
    logic signed [31:0] dx, dy, at;

    assign head_next = heading_reg + q_data.inc;
    assign quad_next = 2'((head_next + 32'h2000_0000) >> 30);
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = $signed(atan_lookup(i_reg));

    assign q_ready = (state_reg == IDLE);
    assign m_valid = (state_reg == OUT);
    assign m_pos_x_out = pos_x_reg;
    assign m_pos_y_out = pos_y_reg;
    assign m_heading_out = heading_reg;
    assign m_gyro_used = gyro_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            heading_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else begin
            unique case (state_reg)
                IDLE: if (q_valid) begin
                    heading_reg <= head_next;
                    quad_reg <= quad_next;
                    z_reg <= $signed(head_next - {quad_next, 30'd0});
                    x_reg <= CordicGainQ30;
                    y_reg <= '0;
                    i_reg <= '0;
                    step_reg <= 32'(q_data.wheel_delta * $signed({1'b0, wheel_radius}));
                    gyro_reg <= q_data.gyro_used;
                    state_reg <= ROT;
                end
                ROT: begin
                    if (!z_reg[31]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == LastStage) state_reg <= MUL1;
                end
                MUL1: begin
                    unique case (quad_reg)
                        2'd0: begin c_reg <= x_reg; s_reg <= y_reg; end
                        2'd1: begin c_reg <= -y_reg; s_reg <= x_reg; end
                        2'd2: begin c_reg <= -x_reg; s_reg <= -y_reg; end
                        default: begin c_reg <= y_reg; s_reg <= -x_reg; end
                    endcase
                    state_reg <= MUL2;
                end
                MUL2: begin
                    px_reg <= step_reg * c_reg;
                    py_reg <= step_reg * s_reg;
                    state_reg <= ACC;
                end
                ACC: begin
                    pos_x_reg <= pos_x_reg + 32'((px_reg + 64'sd2199023255552) >>> 42);
                    pos_y_reg <= pos_y_reg + 32'((py_reg + 64'sd2199023255552) >>> 42);
                    state_reg <= OUT;
                end
                OUT: if (m_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/gyro_fused_dead_reckoning_unit.sv =====
// The back end accepts a new tick only when idle, after the previous result is taken;
// the iterative CORDIC loop does one micro-rotation per cycle, and the front queue
// overlaps input.
// Reset: synchronous active-low aresetn clears heading, position and the handshake
// state and restores register defaults.
module gyro_fused_dead_reckoning_unit
    import gfdr_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_wheel_delta,
    input  logic signed [31:0] s_wheel_heading_delta,
    input  logic signed [15:0] s_yaw_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x_out,
    output logic signed [31:0] m_pos_y_out,
    output logic [31:0]        m_heading_out,
    output logic               m_gyro_used,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic [15:0] gyro_scale_reg, wheel_radius_reg;
    logic [30:0] fusion_threshold_reg;
    logic q_valid, q_ready;
    gfdr_tick_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_scale_reg <= GyroScaleReset;
            fusion_threshold_reg <= FusionThresholdReset;
            wheel_radius_reg <= WheelRadiusReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegGyroScale: gyro_scale_reg <= cfg_data[15:0];
                RegFusionThreshold: fusion_threshold_reg <= cfg_data[30:0];
                RegWheelRadius: wheel_radius_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    gfdr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_wheel_delta, .s_wheel_heading_delta,
        .s_yaw_rate, .gyro_scale(gyro_scale_reg), .fusion_threshold(fusion_threshold_reg),
        .q_valid, .q_ready, .q_data
    );

    gfdr_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .wheel_radius(wheel_radius_reg),
        .m_valid, .m_ready, .m_pos_x_out, .m_pos_y_out, .m_heading_out, .m_gyro_used
    );
endmodule

// ===== hw/rtl/gfdr_checker.sv =====
module gfdr_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_heading_out,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading_out))
        else $error("result beat dropped or changed while stalled");

    a_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("handshake state not cleared by reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("config port not ready");

    a_out_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result repeated");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat withdrawn before accept");
endmodule

bind gyro_fused_dead_reckoning_unit gfdr_assertions u_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_heading_out, .cfg_ready
);
